// File: rtl/owdm_pkg.sv
// shared types, constants and elaboration-time functions of the omni wheel drive mixer
`default_nettype none

package owdm_pkg;

  localparam int TRIG_FRAC_BITS  = 15;
  localparam int SPEED_FRAC_BITS = 8;

  localparam int HEAD_W  = 9;
  localparam int SPEED_W = 7;
  localparam int DUTY_W  = 8;
  localparam int ANGLE_W = 7;

  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 7'd100;
  localparam logic [ANGLE_W-1:0] WHEEL_ANGLE_RST = 7'd45;

  typedef enum logic [0:0] {
    REG_SPEED_LIMIT = 1'b0,
    REG_WHEEL_ANGLE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic zero_all;
    logic n1_zero;
    logic n2_zero;
    logic n1_large;
    logic n1_neg;
    logic n2_neg;
  } mix_flags_t;

  // shift and subtract quotient, used only while building tables
  function automatic longint unsigned udiv_u64(input longint unsigned a,
                                               input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint sine_q30(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = longint'(k) * 64'd18740330;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = udiv_u64(term, 64'((2 * n) * (2 * n + 1)));
      if (n[0] == 1'b1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    return sum;
  endfunction

  function automatic longint sine_quarter(input int k, input int t);
    longint s;
    s = sine_q30(k);
    return (s + (longint'(1) << (29 - t))) >> (30 - t);
  endfunction

endpackage

`default_nettype wire

// File: rtl/owdm_trig.sv
// sine table lookup of heading and wheel angle, then the two cross products
`default_nettype none

module owdm_trig #(
  parameter int TRIG_FRAC_BITS = owdm_pkg::TRIG_FRAC_BITS
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     en_i,
  input  wire logic                                     valid_i,
  input  wire logic [owdm_pkg::HEAD_W-1:0]              heading_i,
  input  wire logic [owdm_pkg::SPEED_W-1:0]             speed_i,
  input  wire logic [owdm_pkg::ANGLE_W-1:0]             angle_i,
  output logic                                          valid_o,
  output logic signed [2*(TRIG_FRAC_BITS+2)-1:0]        p_csa_o,
  output logic signed [2*(TRIG_FRAC_BITS+2)-1:0]        p_sca_o,
  output logic [owdm_pkg::SPEED_W-1:0]                  speed_o
);
  import owdm_pkg::*;

  localparam int T  = TRIG_FRAC_BITS;
  localparam int TW = T + 2;
  localparam int PW = 2 * TW;

  logic [T:0] sin_tab [91];

  for (genvar g = 0; g < 91; g++) begin : g_sin
    assign sin_tab[g] = (T+1)'(sine_quarter(g, T));
  end

  function automatic logic [7:0] quad_map(input logic [HEAD_W-1:0] a);
    logic             neg;
    logic [HEAD_W-1:0] r;
    neg = 1'b0;
    if (a <= 9'd90) begin
      r = a;
    end else if (a <= 9'd180) begin
      r = 9'd180 - a;
    end else if (a <= 9'd270) begin
      r   = a - 9'd180;
      neg = 1'b1;
    end else begin
      r   = 9'd360 - a;
      neg = 1'b1;
    end
    return {neg, r[6:0]};
  endfunction

  logic [HEAD_W-1:0]  h_mod;
  logic [HEAD_W:0]    hc_sum;
  logic [HEAD_W-1:0]  hc_mod;
  logic [7:0]         s_map;
  logic [7:0]         c_map;
  logic [ANGLE_W-1:0] al;
  logic signed [TW-1:0] s_val, c_val, sa_val, ca_val;

  always_comb begin
    h_mod  = (heading_i >= 9'd360) ? heading_i - 9'd360 : heading_i;
    hc_sum = {1'b0, h_mod} + 10'd90;
    hc_mod = (hc_sum >= 10'd360) ? HEAD_W'(hc_sum - 10'd360) : hc_sum[HEAD_W-1:0];
    s_map  = quad_map(h_mod);
    c_map  = quad_map(hc_mod);
    if (angle_i == 7'd0) begin
      al = 7'd1;
    end else if (angle_i > 7'd89) begin
      al = 7'd89;
    end else begin
      al = angle_i;
    end
    s_val  = s_map[7] ? -$signed({1'b0, sin_tab[s_map[6:0]]})
                      :  $signed({1'b0, sin_tab[s_map[6:0]]});
    c_val  = c_map[7] ? -$signed({1'b0, sin_tab[c_map[6:0]]})
                      :  $signed({1'b0, sin_tab[c_map[6:0]]});
    sa_val = $signed({1'b0, sin_tab[al]});
    ca_val = $signed({1'b0, sin_tab[7'd90 - al]});
  end

  logic                  v1_q;
  logic signed [TW-1:0]  s_q, c_q, sa_q, ca_q;
  logic [SPEED_W-1:0]    spd1_q;
  logic                  v2_q;
  logic signed [PW-1:0]  p_csa_q, p_sca_q;
  logic [SPEED_W-1:0]    spd2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q     <= s_val;
      c_q     <= c_val;
      sa_q    <= sa_val;
      ca_q    <= ca_val;
      spd1_q  <= speed_i;
      p_csa_q <= c_q * sa_q;
      p_sca_q <= s_q * ca_q;
      spd2_q  <= spd1_q;
    end
  end

  assign valid_o = v2_q;
  assign p_csa_o = p_csa_q;
  assign p_sca_o = p_sca_q;
  assign speed_o = spd2_q;

endmodule

`default_nettype wire

// File: rtl/owdm_mix.sv
// kinematic components, magnitude compare and ratio numerator
`default_nettype none

module owdm_mix #(
  parameter int TRIG_FRAC_BITS  = owdm_pkg::TRIG_FRAC_BITS,
  parameter int SPEED_FRAC_BITS = owdm_pkg::SPEED_FRAC_BITS,
  parameter int MW = 2 * TRIG_FRAC_BITS + 2
                   - ((2 * TRIG_FRAC_BITS > 30) ? 2 * TRIG_FRAC_BITS - 30 : 0),
  parameter int QW = owdm_pkg::SPEED_W + SPEED_FRAC_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic                                   valid_i,
  input  wire logic signed [2*(TRIG_FRAC_BITS+2)-1:0] p_csa_i,
  input  wire logic signed [2*(TRIG_FRAC_BITS+2)-1:0] p_sca_i,
  input  wire logic [owdm_pkg::SPEED_W-1:0]           speed_i,
  output logic                                        valid_o,
  output owdm_pkg::mix_flags_t                        flags_o,
  output logic [QW-1:0]                               full_o,
  output logic [QW+MW-1:0]                            num_o,
  output logic [MW-1:0]                               div_o
);
  import owdm_pkg::*;

  localparam int T    = TRIG_FRAC_BITS;
  localparam int NW   = 2 * T + 3;
  localparam int MAGW = 2 * T + 2;
  localparam int SH   = MAGW - MW;

  logic signed [NW-1:0] n1, n2;
  logic [NW-1:0]        n1_abs, n2_abs;
  logic [MAGW-1:0]      mag1, mag2;
  mix_flags_t           flags_d;
  logic [MAGW-1:0]      m_small, m_large;

  always_comb begin
    n1     = NW'(p_csa_i) - NW'(p_sca_i);
    n2     = NW'(p_csa_i) + NW'(p_sca_i);
    n1_abs = n1[NW-1] ? NW'(-n1) : NW'(n1);
    n2_abs = n2[NW-1] ? NW'(-n2) : NW'(n2);
    mag1   = n1_abs[MAGW-1:0];
    mag2   = n2_abs[MAGW-1:0];
    flags_d.n1_zero  = (n1 == '0);
    flags_d.n2_zero  = (n2 == '0);
    flags_d.zero_all = (speed_i == '0) || (flags_d.n1_zero && flags_d.n2_zero);
    flags_d.n1_large = (mag1 > mag2);
    flags_d.n1_neg   = n1[NW-1];
    flags_d.n2_neg   = n2[NW-1];
    m_small = flags_d.n1_large ? mag2 : mag1;
    m_large = flags_d.n1_large ? mag1 : mag2;
  end

  logic             v3_q;
  mix_flags_t       fl3_q;
  logic [QW-1:0]    full3_q;
  logic [MW-1:0]    ms3_q, ml3_q;
  logic             v4_q;
  mix_flags_t       fl4_q;
  logic [QW-1:0]    full4_q;
  logic [QW+MW-1:0] num4_q;
  logic [MW-1:0]    div4_q;
  logic             general;
  logic [QW+MW-1:0] num_d;
  logic [MW-1:0]    div_d;

  always_comb begin
    general = !fl3_q.zero_all && !fl3_q.n1_zero && !fl3_q.n2_zero;
    num_d   = general ? (QW+MW)'(full3_q * ms3_q) : '0;
    div_d   = (!general || ml3_q == '0) ? MW'(1) : ml3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl3_q   <= flags_d;
      full3_q <= {speed_i, SPEED_FRAC_BITS'(0)};
      ms3_q   <= MW'(m_small >> SH);
      ml3_q   <= MW'(m_large >> SH);
      fl4_q   <= fl3_q;
      full4_q <= full3_q;
      num4_q  <= num_d;
      div4_q  <= div_d;
    end
  end

  assign valid_o = v4_q;
  assign flags_o = fl4_q;
  assign full_o  = full4_q;
  assign num_o   = num4_q;
  assign div_o   = div4_q;

endmodule

`default_nettype wire

// File: rtl/owdm_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module owdm_div #(
  parameter int QW = owdm_pkg::SPEED_W + owdm_pkg::SPEED_FRAC_BITS,
  parameter int MW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire owdm_pkg::mix_flags_t flags_i,
  input  wire logic [QW-1:0]        full_i,
  input  wire logic [QW+MW-1:0]     num_i,
  input  wire logic [MW-1:0]        div_i,
  output logic                      valid_o,
  output owdm_pkg::mix_flags_t      flags_o,
  output logic [QW-1:0]             full_o,
  output logic [QW-1:0]             quo_o
);
  import owdm_pkg::*;

  logic             v_q    [QW];
  mix_flags_t       fl_q   [QW];
  logic [QW-1:0]    full_q [QW];
  logic [MW-1:0]    rem_q  [QW];
  logic [QW-1:0]    low_q  [QW];
  logic [QW-1:0]    quo_q  [QW];
  logic [MW-1:0]    dv_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic             v_in;
    mix_flags_t       fl_in;
    logic [QW-1:0]    full_in;
    logic [MW-1:0]    rem_in;
    logic [QW-1:0]    low_in;
    logic [QW-1:0]    quo_in;
    logic [MW-1:0]    dv_in;
    logic [MW:0]      trial;
    logic             ge;
    logic [MW:0]      diff;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign fl_in   = flags_i;
      assign full_in = full_i;
      assign rem_in  = num_i[QW+MW-1:QW];
      assign low_in  = num_i[QW-1:0];
      assign quo_in  = '0;
      assign dv_in   = div_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign fl_in   = fl_q[j-1];
      assign full_in = full_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign low_in  = low_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign dv_in   = dv_q[j-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QW-1]};
      ge    = (trial >= {1'b0, dv_in});
      diff  = trial - {1'b0, dv_in};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[j]   <= fl_in;
        full_q[j] <= full_in;
        rem_q[j]  <= ge ? diff[MW-1:0] : trial[MW-1:0];
        low_q[j]  <= low_in << 1;
        quo_q[j]  <= {quo_in[QW-2:0], ge};
        dv_q[j]   <= dv_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign flags_o = fl_q[QW-1];
  assign full_o  = full_q[QW-1];
  assign quo_o   = quo_q[QW-1];

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW-1] |-> (rem_q[QW-1] < dv_q[QW-1]))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: rtl/owdm_drive.sv
// wheel speed clamp, direction bit and pwm duty for one motor
`default_nettype none

module owdm_drive #(
  parameter int SPEED_FRAC_BITS = owdm_pkg::SPEED_FRAC_BITS
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              en_i,
  input  wire logic signed [owdm_pkg::SPEED_W+SPEED_FRAC_BITS:0] speed_i,
  input  wire logic [owdm_pkg::SPEED_W-1:0]                      limit_i,
  output logic                                                   reverse_o,
  output logic [owdm_pkg::DUTY_W-1:0]                            duty_o
);
  import owdm_pkg::*;

  localparam int F  = SPEED_FRAC_BITS;
  localparam int QW = SPEED_W + F;
  localparam int SW = QW + 1;
  localparam int XW = 15;
  localparam logic [QW-1:0] FULL100 = QW'(100) << F;
  localparam logic [15:0]   RECIP100 = 16'd41944;

  logic signed [SW-1:0] lim_s;
  logic signed [SW-1:0] s_cl;
  logic signed [SW-1:0] s_mag;
  logic [QW-1:0]        v;
  logic [QW+7:0]        v_prod;
  logic                 neg;

  always_comb begin
    lim_s = $signed({1'b0, limit_i, F'(0)});
    if (speed_i > lim_s) begin
      s_cl = lim_s;
    end else if (speed_i < -lim_s) begin
      s_cl = -lim_s;
    end else begin
      s_cl = speed_i;
    end
    neg   = s_cl[SW-1];
    s_mag = -s_cl;
    if (!neg) begin
      v = s_cl[QW-1:0];
    end else if (s_mag[QW-1:0] > FULL100) begin
      v = '0;
    end else begin
      v = FULL100 - s_mag[QW-1:0];
    end
    v_prod = v * 8'd255;
  end

  logic          rev_a_q;
  logic [XW-1:0] x_a_q;
  logic          rev_b_q;
  logic [7:0]    duty_b_q;
  logic [XW+15:0] q_prod;
  logic [8:0]    q_div;

  always_comb begin
    q_prod = x_a_q * RECIP100;
    q_div  = q_prod[XW+15:22];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rev_a_q  <= neg;
      x_a_q    <= v_prod[F +: XW];
      rev_b_q  <= rev_a_q;
      duty_b_q <= (q_div > 9'd255) ? 8'd255 : q_div[7:0];
    end
  end

  assign reverse_o = rev_b_q;
  assign duty_o    = duty_b_q;

endmodule

`default_nettype wire

// File: rtl/omni_wheel_drive_mixer_core.sv
// Four-wheel omni drive mixer: turns a heading and a speed into four motor
// direction bits and pwm duties. One command is taken every clock cycle when
// the output side keeps up. The divider forms the smaller wheel speed one
// quotient bit per stage. A stalled output holds the whole pipe.
// Configuration writes are always taken and act at once on words in flight,
// so write them only while the pipe is empty.
`default_nettype none

module omni_wheel_drive_mixer_core #(
  parameter int TRIG_FRAC_BITS  = owdm_pkg::TRIG_FRAC_BITS,
  parameter int SPEED_FRAC_BITS = owdm_pkg::SPEED_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // heading_deg, speed_percent
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // m1_reverse, m1_duty, m2_reverse, m2_duty, m3_reverse, m3_duty,
  // m4_reverse, m4_duty, zero fill
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [6:0]  cfg_data_i
);
  import owdm_pkg::*;

  localparam int T  = TRIG_FRAC_BITS;
  localparam int F  = SPEED_FRAC_BITS;
  localparam int PW = 2 * (T + 2);
  localparam int SH = (2 * T > 30) ? 2 * T - 30 : 0;
  localparam int MW = 2 * T + 2 - SH;
  localparam int QW = SPEED_W + F;
  localparam int SW = QW + 1;

  logic en;
  logic [SPEED_W-1:0] speed_limit_q;
  logic [ANGLE_W-1:0] wheel_angle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= SPEED_LIMIT_RST;
      wheel_angle_q <= WHEEL_ANGLE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_SPEED_LIMIT: speed_limit_q <= cfg_data_i;
        REG_WHEEL_ANGLE: wheel_angle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                  trig_valid;
  logic signed [PW-1:0]  p_csa, p_sca;
  logic [SPEED_W-1:0]    trig_speed;

  owdm_trig #(.TRIG_FRAC_BITS(T)) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .heading_i (s_axis_tdata[8:0]),
    .speed_i   (s_axis_tdata[15:9]),
    .angle_i   (wheel_angle_q),
    .valid_o   (trig_valid),
    .p_csa_o   (p_csa),
    .p_sca_o   (p_sca),
    .speed_o   (trig_speed)
  );

  logic             mix_valid;
  mix_flags_t       mix_flags;
  logic [QW-1:0]    mix_full;
  logic [QW+MW-1:0] mix_num;
  logic [MW-1:0]    mix_div;

  owdm_mix #(
    .TRIG_FRAC_BITS  (T),
    .SPEED_FRAC_BITS (F),
    .MW              (MW),
    .QW              (QW)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (trig_valid),
    .p_csa_i (p_csa),
    .p_sca_i (p_sca),
    .speed_i (trig_speed),
    .valid_o (mix_valid),
    .flags_o (mix_flags),
    .full_o  (mix_full),
    .num_o   (mix_num),
    .div_o   (mix_div)
  );

  logic          div_valid;
  mix_flags_t    div_flags;
  logic [QW-1:0] div_full;
  logic [QW-1:0] div_quo;

  owdm_div #(.QW(QW), .MW(MW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mix_valid),
    .flags_i (mix_flags),
    .full_i  (mix_full),
    .num_i   (mix_num),
    .div_i   (mix_div),
    .valid_o (div_valid),
    .flags_o (div_flags),
    .full_o  (div_full),
    .quo_o   (div_quo)
  );

  logic signed [SW-1:0] full_s, quo_s, u1, u2;
  logic signed [SW-1:0] wheel [4];

  always_comb begin
    full_s = $signed({1'b0, div_full});
    quo_s  = $signed({1'b0, div_quo});
    if (div_flags.zero_all) begin
      u1 = '0;
      u2 = '0;
    end else if (div_flags.n1_zero) begin
      u1 = '0;
      u2 = full_s;
    end else if (div_flags.n2_zero) begin
      u1 = full_s;
      u2 = '0;
    end else if (div_flags.n1_large) begin
      u1 = div_flags.n1_neg ? -full_s : full_s;
      u2 = div_flags.n2_neg ? -quo_s  : quo_s;
    end else begin
      u2 = div_flags.n2_neg ? -full_s : full_s;
      u1 = div_flags.n1_neg ? -quo_s  : quo_s;
    end
    wheel[0] = -u1;
    wheel[1] = u2;
    wheel[2] = u1;
    wheel[3] = u2;
  end

  logic               va_q, vb_q;
  logic               rev  [4];
  logic [DUTY_W-1:0]  duty [4];

  for (genvar m = 0; m < 4; m++) begin : g_motor
    owdm_drive #(.SPEED_FRAC_BITS(F)) u_drive (
      .clk_i     (clk_i),
      .en_i      (en),
      .speed_i   (wheel[m]),
      .limit_i   (speed_limit_q),
      .reverse_o (rev[m]),
      .duty_o    (duty[m])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= div_valid;
      vb_q <= va_q;
    end
  end

  assign en            = !vb_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vb_q;
  assign m_axis_tdata  = {4'b0,
                          duty[3], rev[3], duty[2], rev[2],
                          duty[1], rev[1], duty[0], rev[0]};

  a_m2_m4_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rev[1] == rev[3] && duty[1] == duty[3]))
    else $error("motors two and four differ");

  a_m1_m3_opposed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(rev[0] && rev[2]))
    else $error("motors one and three both reversing");

endmodule

`default_nettype wire
